### sv/pbv_pkg.sv
// Shared types, codes and sizes for the packed bit vector block.
package pbv_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int POS_W = 7;

	localparam logic [1:0] FN_APPEND = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_ERASE  = 2'd2;
	localparam logic [1:0] FN_READ   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]       func;
		logic [POS_W-1:0] position;
		logic             bit_in;
	} req_t;

	typedef struct packed {
		logic             bit_out;
		logic [POS_W-1:0] length;
		logic [1:0]       status;
	} rsp_t;

	typedef struct packed {
		logic exec;
		logic drain;
	} cmd_t;

endpackage

### sv/pbv_ctrl.sv
// Handshake controller: tracks the result register and issues execute commands.
module pbv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pbv_pkg::cmd_t cmd
);
	import pbv_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_HOLD = 1'b1;

	logic state_q;
	logic state_d;

	assign rsp_valid = (state_q == S_HOLD);
	// A new item may enter whenever the result register is empty or drains now.
	assign req_stall = (state_q == S_HOLD) && rsp_stall;
	assign cmd.exec  = req_valid && !req_stall;
	assign cmd.drain = rsp_valid && !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.exec) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (cmd.exec) state_d = S_HOLD;
				else if (cmd.drain) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

### sv/pbv_dp.sv
// Datapath: bit store, length count, insert/erase shift network and result register.
module pbv_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  pbv_pkg::cmd_t cmd,
	input  pbv_pkg::req_t req,
	output pbv_pkg::rsp_t rsp
);
	import pbv_pkg::*;

	logic [CAPACITY-1:0] store_q;
	logic [CNT_W-1:0]    cnt_q;
	rsp_t                rsp_q;

	logic [CAPACITY-1:0] up_v, down_v, ins_v, ers_v, store_d;
	logic [POS_W-1:0]    cnt_ext, ins_pos;
	logic [CNT_W-1:0]    cnt_d;
	logic                full, pos_gt, pos_ge, rd_bit;
	rsp_t                rsp_d;

	assign cnt_ext = POS_W'(cnt_q);
	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign pos_gt  = (req.position > cnt_ext);
	assign pos_ge  = (req.position >= cnt_ext);

	// An append is an insert at the current length, since bits past it are zero.
	assign ins_pos = (req.func == FN_APPEND) ? cnt_ext : req.position;
	assign up_v    = {store_q[CAPACITY-2:0], 1'b0};
	assign down_v  = {1'b0, store_q[CAPACITY-1:1]};
	assign rd_bit  = store_q[req.position[IDX_W-1:0]];

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (POS_W'(i) < ins_pos) ins_v[i] = store_q[i];
			else if (POS_W'(i) == ins_pos) ins_v[i] = req.bit_in;
			else ins_v[i] = up_v[i];
			if (POS_W'(i) < req.position) ers_v[i] = store_q[i];
			else ers_v[i] = down_v[i];
		end
	end

	always_comb begin
		store_d = store_q;
		cnt_d   = cnt_q;
		rsp_d   = '0;
		rsp_d.status = ST_OK;
		case (req.func)
			FN_APPEND, FN_INSERT: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else if (req.func == FN_INSERT && pos_gt) begin
					rsp_d.status = ST_RANGE;
				end else begin
					store_d = ins_v;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			FN_ERASE: begin
				if (cnt_q == '0) begin
					rsp_d.status = ST_EMPTY;
				end else if (pos_ge) begin
					rsp_d.status = ST_RANGE;
				end else begin
					store_d = ers_v;
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				if (pos_ge) rsp_d.status = ST_RANGE;
				else rsp_d.bit_out = rd_bit;
			end
		endcase
		rsp_d.length = POS_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.exec) begin
			store_q <= store_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) rsp_q <= rsp_d;
	end

	assign rsp = rsp_q;

endmodule

### sv/packed_bit_vector_insert_erase_core.sv
// Top level of the packed bit vector with append, insert, erase and read.
// Usage:
//   The request channel (req_valid, req_stall, req) carries one item per
//   operation: func, position and bit_in. The response channel (rsp_valid,
//   rsp_stall, rsp) returns one item per request: bit_out, length, status.
//   An item moves at a rising edge with valid high and stall low.
// Latency: the response is valid in the cycle after the request is taken.
// Throughput: one request per cycle while rsp_stall is low; the insert or
//   erase shift over the CAPACITY-bit store and the status checks are
//   combinational; the result register refills in the same cycle it drains.
// Reset: arst_n low empties the vector (length zero, all bits zero) and
//   clears the response register's valid flag.
// Stall: while a response waits under rsp_stall, req_stall is raised and
//   the response holds; requests resume as soon as the response is taken.
module packed_bit_vector_insert_erase_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pbv_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pbv_pkg::rsp_t rsp
);
	import pbv_pkg::*;

	cmd_t cmd;

	pbv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	pbv_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	// Every accepted request shows a response in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> rsp_valid)
		else $error("response missing after accepted request");

	// A waiting response must block new requests so it cannot be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |-> req_stall)
		else $error("request accepted while response stalled");

	// The reported length never exceeds the capacity.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.length <= POS_W'(CAPACITY)))
		else $error("length beyond capacity");

endmodule
